FILE: rtl/vfe_pkg.sv
// Shared types, constants and codes of the volume fade envelope block.
package vfe_pkg;

	// Field and datapath widths
	localparam int LEVEL_W    = 16;
	localparam int VOLUME_W   = 8;
	localparam int GAIN_W     = 9;
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Serial multiplier operand widths: the multiplicand is the widest partial
	// product that is fed back (17 bits), the multiplier is the envelope level.
	localparam int MCAND_W  = 17;
	localparam int MPLIER_W = 16;
	localparam int PROD_W   = MCAND_W + MPLIER_W;
	localparam int CNT_W    = $clog2(MPLIER_W);

	// Level and byte limits
	localparam logic [LEVEL_W-1:0] FULL_LEVEL = 16'h8000;
	localparam logic [BYTE_W-1:0]  BYTE_MAX   = 8'hff;

	// Item opcodes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_VOLUME = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_GAIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRACK_GAIN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRACK_MASK     = 3'd3;

	// Configuration reset values
	localparam logic [VOLUME_W-1:0] VOLUME_RESET = 8'hff;
	localparam logic [GAIN_W-1:0]   GAIN_UNITY   = 9'h100;

	// Fade modes
	typedef enum logic [1:0] {
		MODE_NONE      = 2'd0,
		MODE_IN        = 2'd1,
		MODE_OUT_STOP  = 2'd2,
		MODE_OUT_PAUSE = 2'd3
	} fade_mode_t;

	// Envelope state as seen by the sequencer
	typedef struct packed {
		fade_mode_t         mode;
		logic [LEVEL_W-1:0] level;
		logic               stop;
		logic               pause;
	} env_state_t;

	// Request to the serial multiplier
	typedef struct packed {
		logic                start;
		logic [MCAND_W-1:0]  mcand;
		logic [MPLIER_W-1:0] mplier;
	} smul_req_t;

	// Answer of the serial multiplier
	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] prod;
	} smul_rsp_t;

endpackage

FILE: rtl/vfe_env.sv
// Envelope state of the fade engine: mode, level, step and the request flags.
module vfe_env (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic                           opcode,
	input  logic [1:0]                     new_mode,
	input  logic [vfe_pkg::LEVEL_W-1:0]    new_step,
	input  logic [vfe_pkg::LEVEL_W-1:0]    new_level,
	output vfe_pkg::env_state_t            env
);
	import vfe_pkg::*;

	fade_mode_t         mode_q, mode_d;
	logic [LEVEL_W-1:0] level_q, level_d;
	logic [LEVEL_W-1:0] step_q, step_d;
	logic               stop_q, stop_d;
	logic               pause_q, pause_d;
	logic [LEVEL_W-1:0] level_up;
	logic [LEVEL_W-1:0] level_down;
	logic               under;

	// Both directions of the level update, the sum wrapping at 16 bits
	assign level_up   = level_q + step_q;
	assign level_down = level_q - step_q;
	assign under      = level_q < step_q;

	// Next state for one item
	always_comb begin
		mode_d  = mode_q;
		level_d = level_q;
		step_d  = step_q;
		stop_d  = 1'b0;
		pause_d = 1'b0;
		if (opcode == OP_START) begin
			mode_d  = fade_mode_t'(new_mode);
			step_d  = new_step;
			level_d = new_level;
		end else begin
			case (mode_q)
				MODE_IN: begin
					if (level_up[LEVEL_W-1]) begin
						mode_d  = MODE_NONE;
						level_d = FULL_LEVEL;
						step_d  = '0;
					end else begin
						level_d = level_up;
					end
				end
				MODE_OUT_STOP: begin
					if (under) begin
						mode_d  = MODE_NONE;
						level_d = '0;
						stop_d  = 1'b1;
					end else begin
						level_d = level_down;
					end
				end
				MODE_OUT_PAUSE: begin
					if (under) begin
						level_d = '0;
						pause_d = 1'b1;
					end else begin
						level_d = level_down;
					end
				end
				default: begin
					level_d = level_q;
				end
			endcase
		end
	end

	// State registers, updated once per accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NONE;
			level_q <= FULL_LEVEL;
			step_q  <= '0;
			stop_q  <= 1'b0;
			pause_q <= 1'b0;
		end else if (accept) begin
			mode_q  <= mode_d;
			level_q <= level_d;
			step_q  <= step_d;
			stop_q  <= stop_d;
			pause_q <= pause_d;
		end
	end

	assign env.mode  = mode_q;
	assign env.level = level_q;
	assign env.stop  = stop_q;
	assign env.pause = pause_q;

endmodule

FILE: rtl/vfe_smul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module vfe_smul (
	input  logic                clk,
	input  logic                arst_n,
	input  vfe_pkg::smul_req_t  req,
	output vfe_pkg::smul_rsp_t  rsp
);
	import vfe_pkg::*;

	logic [MCAND_W-1:0]  mcand_q;
	logic [MCAND_W-1:0]  hi_q;
	logic [MPLIER_W-1:0] lo_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [MCAND_W:0]    sum;
	logic                last;

	// Add the multiplicand when the low multiplier bit is set
	assign sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);
	assign last = cnt_q == CNT_W'(MPLIER_W - 1);

	// Control: step counter and the done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && last;
			if (req.start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: the partial sum shifts right into the multiplier register
	always_ff @(posedge clk) begin
		if (req.start) begin
			mcand_q <= req.mcand;
			hi_q    <= '0;
			lo_q    <= req.mplier;
		end else if (busy_q) begin
			hi_q <= sum[MCAND_W:1];
			lo_q <= {sum[0], lo_q[MPLIER_W-1:1]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = {hi_q, lo_q};

endmodule

FILE: rtl/volume_fade_envelope_core.sv
// Top level of the volume fade envelope: config, sequencer and result register.
//
// One item goes in on the input channel (in_valid / in_ready): a frame tick or
// the start of a fade. The block updates the envelope and then forms the master
// and track volume bytes with one shared bit-serial multiplier, which runs three
// products in turn (volume times gain, that times the level, the upper part
// times the track gain), 16 multiplier bits each. One item is worked on at a
// time; the next one is accepted in the cycle after the result has moved into
// the output register.
// Results leave on the output channel (out_valid / out_ready). A result that
// the receiver does not take stays in the output register while the next item
// is accepted and computed; that item then waits until the register is free.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// are to be made while the block is idle; the user must keep to this, as the
// block has no check for it. Reset clears the envelope to full level with no
// fade, and sets unity gains and full base volume.
module volume_fade_envelope_core (
	input  logic                             clk,
	input  logic                             arst_n,
	// Configuration write port
	input  logic                             cfg_we,
	input  logic [vfe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vfe_pkg::CFG_DATA_W-1:0]   cfg_data,
	// Input channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             opcode,
	input  logic [1:0]                       new_mode,
	input  logic [vfe_pkg::LEVEL_W-1:0]      new_step,
	input  logic [vfe_pkg::LEVEL_W-1:0]      new_level,
	// Output channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [vfe_pkg::BYTE_W-1:0]       master_level,
	output logic [vfe_pkg::BYTE_W-1:0]       track_level,
	output logic                             stop_request,
	output logic                             pause_request,
	output logic [1:0]                       mode_now
);
	import vfe_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_MUL_VG = 5'b00010,
		ST_MUL_L  = 5'b00100,
		ST_MUL_T  = 5'b01000,
		ST_DONE   = 5'b10000
	} seq_state_t;

	seq_state_t          state_q, state_d;
	logic [VOLUME_W-1:0] channel_volume_q;
	logic [GAIN_W-1:0]   channel_gain_q;
	logic [GAIN_W-1:0]   track_gain_q;
	logic [BYTE_W-1:0]   master_q;
	logic [BYTE_W-1:0]   track_q;
	logic                out_valid_q;
	logic [BYTE_W-1:0]   master_level_q;
	logic [BYTE_W-1:0]   track_level_q;
	logic                stop_request_q;
	logic                pause_request_q;
	logic [1:0]          mode_now_q;
	logic                in_accept;
	logic                out_free;
	logic                load_out;
	env_state_t          env;
	smul_req_t           mul_req;
	smul_rsp_t           mul_rsp;
	logic [BYTE_W-1:0]   master_sat;
	logic [BYTE_W-1:0]   track_sat;

	assign in_ready  = state_q == ST_IDLE;
	assign in_accept = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign load_out  = (state_q == ST_DONE) && out_free;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_volume_q <= VOLUME_RESET;
			channel_gain_q   <= GAIN_UNITY;
			track_gain_q     <= GAIN_UNITY;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CHANNEL_VOLUME: channel_volume_q <= cfg_data[VOLUME_W-1:0];
				REG_CHANNEL_GAIN:   channel_gain_q   <= cfg_data[GAIN_W-1:0];
				REG_TRACK_GAIN:     track_gain_q     <= cfg_data[GAIN_W-1:0];
				// The track mask is not stored here; no level uses it.
				REG_TRACK_MASK:     channel_volume_q <= channel_volume_q;
				default:            channel_volume_q <= channel_volume_q;
			endcase
		end
	end

	// Envelope state
	vfe_env u_env (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_accept),
		.opcode    (opcode),
		.new_mode  (new_mode),
		.new_step  (new_step),
		.new_level (new_level),
		.env       (env)
	);

	// Shared serial multiplier
	vfe_smul u_smul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// Saturate the top bits of the level products to one byte
	assign master_sat = (|mul_rsp.prod[PROD_W-1:31]) ? BYTE_MAX : mul_rsp.prod[30:23];
	assign track_sat  = (|mul_rsp.prod[PROD_W-1:23]) ? BYTE_MAX : mul_rsp.prod[22:15];

	// Sequencer: issue each product as the previous one completes
	always_comb begin
		state_d        = state_q;
		mul_req.start  = 1'b0;
		mul_req.mcand  = MCAND_W'(channel_gain_q);
		mul_req.mplier = MPLIER_W'(channel_volume_q);
		case (state_q)
			ST_IDLE: begin
				mul_req.start = in_accept;
				if (in_accept) begin
					state_d = ST_MUL_VG;
				end
			end
			ST_MUL_VG: begin
				mul_req.start  = mul_rsp.done;
				mul_req.mcand  = mul_rsp.prod[MCAND_W-1:0];
				mul_req.mplier = env.level;
				if (mul_rsp.done) begin
					state_d = ST_MUL_L;
				end
			end
			ST_MUL_L: begin
				mul_req.start  = mul_rsp.done;
				mul_req.mcand  = mul_rsp.prod[PROD_W-1:16];
				mul_req.mplier = MPLIER_W'(track_gain_q);
				if (mul_rsp.done) begin
					state_d = ST_MUL_T;
				end
			end
			ST_MUL_T: begin
				if (mul_rsp.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Level bytes as the second and third products complete
	always_ff @(posedge clk) begin
		if ((state_q == ST_MUL_L) && mul_rsp.done) begin
			master_q <= master_sat;
		end
		if ((state_q == ST_MUL_T) && mul_rsp.done) begin
			track_q <= track_sat;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			master_level_q  <= master_q;
			track_level_q   <= track_q;
			stop_request_q  <= env.stop;
			pause_request_q <= env.pause;
			mode_now_q      <= env.mode;
		end
	end

	assign out_valid     = out_valid_q;
	assign master_level  = master_level_q;
	assign track_level   = track_level_q;
	assign stop_request  = stop_request_q;
	assign pause_request = pause_request_q;
	assign mode_now      = mode_now_q;

endmodule
